/* rtl/core/assert_macros.svh */
// Assertion macros used by the RTL of the pulse-pair frame transmitter.
// Depends on nothing; include by bare file name where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define PPFT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define PPFT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/core/ppft_pkg.sv */
// Package of the pulse-pair frame transmitter: widths, register indexes,
// reset values, shared structs and helper functions. Depends on nothing.
package ppft_pkg;

   // Fixed field widths
   localparam int SYS_CODE_W  = 14;
   localparam int TICKS_W     = 16;
   localparam int VALUE_W     = 30;
   localparam int TYPE_W      = 4;
   localparam int REPEAT_W    = 8;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 16;

   // Widest frame fields the parameters may ask for
   localparam int CODE_MAX_W  = 32;
   localparam int VALUE_MAX_W = 32;
   localparam int TYPE_MAX_W  = 8;

   // Default frame layout
   localparam int DEF_CODE_BITS  = 14;
   localparam int DEF_VALUE_BITS = 30;
   localparam int DEF_TYPE_BITS  = 4;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SYSTEM_CODE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HIGH_TICKS  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SHORT_LOW   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_LOW    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_END_LOW     = 3'd4;

   // Register reset values
   localparam logic [TICKS_W-1:0] RST_HIGH_TICKS = 16'd650;
   localparam logic [TICKS_W-1:0] RST_SHORT_LOW  = 16'd2024;
   localparam logic [TICKS_W-1:0] RST_LONG_LOW   = 16'd4301;
   localparam logic [TICKS_W-1:0] RST_END_LOW    = 16'd8602;

   // Request commands
   localparam logic CMD_TICK  = 1'b0;
   localparam logic CMD_START = 1'b1;

   typedef struct packed {
      logic [TICKS_W-1:0] high_ticks;
      logic [TICKS_W-1:0] short_low_ticks;
      logic [TICKS_W-1:0] long_low_ticks;
      logic [TICKS_W-1:0] end_low_ticks;
   } timing_type;

   typedef struct packed {
      logic                command;
      logic                positive;
      logic [VALUE_W-1:0]  value;
      logic [TYPE_W-1:0]   type_bits;
      logic [REPEAT_W-1:0] repeat_count;
   } req_type;

   typedef struct packed {
      logic line_level;
      logic busy_res;
      logic start_refused;
   } rsp_type;

   // A phase length of zero counts as one tick.
   function automatic logic [TICKS_W-1:0] phase_len(input logic [TICKS_W-1:0] v);
      return (v == '0) ? TICKS_W'(1) : v;
   endfunction

endpackage

/* rtl/core/pulse_pair_frame_transmitter.sv */
// Pulse-pair frame transmitter: each request beat taken in has its result
// beat appear from the result register on the next clock. The block takes a
// request beat in every cycle unless that register holds an untaken result
// beat and rsp_stall is high; the only limit is this one result register.
// A start beat latches a frame (system code, type bits, sign flag, value, MSB
// first) and sends it repeat_count times; tick beats advance time by one. Each
// result beat reports the line level, busy, and whether the start was refused.
// Depends on ppft_pkg, ppft_csr, ppft_seq and assert_macros.svh.
`include "assert_macros.svh"

module pulse_pair_frame_transmitter #(
   parameter int CODE_BITS  = ppft_pkg::DEF_CODE_BITS,
   parameter int VALUE_BITS = ppft_pkg::DEF_VALUE_BITS,
   parameter int TYPE_BITS  = ppft_pkg::DEF_TYPE_BITS
) (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_command,
   input  logic                            req_positive,
   input  logic [ppft_pkg::VALUE_W-1:0]    req_value,
   input  logic [ppft_pkg::TYPE_W-1:0]     req_type_bits,
   input  logic [ppft_pkg::REPEAT_W-1:0]   req_repeat_count,
   // result channel
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_line_level,
   output logic                            rsp_busy_res,
   output logic                            rsp_start_refused,
   // configuration write channel
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [ppft_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ppft_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import ppft_pkg::*;

   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff;
   rsp_type               seq_rsp;
   req_type               req;
   timing_type            timing;
   logic [SYS_CODE_W-1:0] system_code;
   logic                  req_accept;

   // Hold the request side only while a result beat is stuck in the register
   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;

   assign req.command      = req_command;
   assign req.positive     = req_positive;
   assign req.value        = req_value;
   assign req.type_bits    = req_type_bits;
   assign req.repeat_count = req_repeat_count;

   ppft_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .system_code (system_code),
      .timing      (timing)
   );

   ppft_seq #(
      .CODE_BITS  (CODE_BITS),
      .VALUE_BITS (VALUE_BITS),
      .TYPE_BITS  (TYPE_BITS)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .step        (req_accept),
      .req         (req),
      .system_code (system_code),
      .timing      (timing),
      .rsp         (seq_rsp)
   );

   // Load a new result on every accepted request; keep a stalled one
   assign rsp_valid_in = req_accept || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_ff <= seq_rsp;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_line_level    = rsp_ff.line_level;
   assign rsp_busy_res      = rsp_ff.busy_res;
   assign rsp_start_refused = rsp_ff.start_refused;

   // A refused start leaves the transmission running
   `PPFT_ASSERT_NOW(a_refused_busy, clock, reset, rsp_valid_ff && rsp_ff.start_refused, rsp_ff.busy_res, "refused start reported while idle")
   // The line only goes high during a transmission
   `PPFT_ASSERT_NOW(a_line_busy, clock, reset, rsp_valid_ff && rsp_ff.line_level, rsp_ff.busy_res, "line high while idle")
   // An accepted request always produces a result beat next cycle
   `PPFT_ASSERT_NEXT(a_accept_rsp, clock, reset, req_accept, rsp_valid_ff, "accepted request without result beat")

endmodule

/* rtl/core/ppft_csr.sv */
// Configuration registers of the pulse-pair frame transmitter.
// Depends on ppft_pkg.
module ppft_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [ppft_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [ppft_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output logic [ppft_pkg::SYS_CODE_W-1:0]     system_code,
   output ppft_pkg::timing_type                timing
);
   import ppft_pkg::*;

   logic [SYS_CODE_W-1:0] system_code_ff, system_code_in;
   timing_type            timing_ff, timing_in;

   assign csr_ready = 1'b1;

   always_comb begin
      system_code_in = system_code_ff;
      timing_in      = timing_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_SYSTEM_CODE: system_code_in = csr_wdata[SYS_CODE_W-1:0];
            CSR_HIGH_TICKS:  timing_in.high_ticks      = csr_wdata[TICKS_W-1:0];
            CSR_SHORT_LOW:   timing_in.short_low_ticks = csr_wdata[TICKS_W-1:0];
            CSR_LONG_LOW:    timing_in.long_low_ticks  = csr_wdata[TICKS_W-1:0];
            CSR_END_LOW:     timing_in.end_low_ticks   = csr_wdata[TICKS_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         system_code_ff            <= '0;
         timing_ff.high_ticks      <= RST_HIGH_TICKS;
         timing_ff.short_low_ticks <= RST_SHORT_LOW;
         timing_ff.long_low_ticks  <= RST_LONG_LOW;
         timing_ff.end_low_ticks   <= RST_END_LOW;
      end else begin
         system_code_ff <= system_code_in;
         timing_ff      <= timing_in;
      end
   end

   assign system_code = system_code_ff;
   assign timing      = timing_ff;

endmodule

/* rtl/core/ppft_seq.sv */
// Symbol sequencer of the pulse-pair frame transmitter: frame latch, phase
// counter and one-step next-state logic. Depends on ppft_pkg.
module ppft_seq #(
   parameter int CODE_BITS  = ppft_pkg::DEF_CODE_BITS,
   parameter int VALUE_BITS = ppft_pkg::DEF_VALUE_BITS,
   parameter int TYPE_BITS  = ppft_pkg::DEF_TYPE_BITS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            step,
   input  ppft_pkg::req_type               req,
   input  logic [ppft_pkg::SYS_CODE_W-1:0] system_code,
   input  ppft_pkg::timing_type            timing,
   output ppft_pkg::rsp_type               rsp
);
   import ppft_pkg::*;

   localparam int FRAME_LEN = CODE_BITS + TYPE_BITS + 1 + VALUE_BITS;
   localparam int POS_W     = $clog2(FRAME_LEN + 1);
   localparam int IDX_W     = $clog2(FRAME_LEN);

   logic [FRAME_LEN-1:0] frame_ff, frame_in;
   logic [POS_W-1:0]     bit_position_ff, bit_position_in;
   logic                 second_half_ff, second_half_in;
   logic                 in_low_phase_ff, in_low_phase_in;
   logic                 in_end_marker_ff, in_end_marker_in;
   logic [TICKS_W-1:0]   ticks_left_ff, ticks_left_in;
   logic [REPEAT_W-1:0]  repeats_left_ff, repeats_left_in;
   logic                 active_ff, active_in;

   logic [CODE_MAX_W-1:0]  code_ext;
   logic [VALUE_MAX_W-1:0] value_ext;
   logic [TYPE_MAX_W-1:0]  type_ext;
   logic [IDX_W-1:0]       sel_idx;
   logic                   cur_bit;
   logic                   symbol;
   logic [TICKS_W-1:0]     ticks_dec;
   logic [POS_W-1:0]       pos_inc;
   logic [REPEAT_W-1:0]    reps_dec;
   logic                   refused;

   assign code_ext  = CODE_MAX_W'(system_code);
   assign value_ext = VALUE_MAX_W'(req.value);
   assign type_ext  = TYPE_MAX_W'(req.type_bits);

   // Frame position p sits at vector bit FRAME_LEN-1-p
   assign sel_idx   = IDX_W'(FRAME_LEN - 1) - bit_position_ff[IDX_W-1:0];
   assign cur_bit   = (bit_position_ff < POS_W'(FRAME_LEN)) ? frame_ff[sel_idx] : 1'b0;
   assign symbol    = cur_bit ^ second_half_ff;
   assign ticks_dec = ticks_left_ff - TICKS_W'(ticks_left_ff != '0);
   assign pos_inc   = bit_position_ff + POS_W'(1);
   assign reps_dec  = repeats_left_ff - REPEAT_W'(repeats_left_ff != '0);

   always_comb begin
      frame_in         = frame_ff;
      bit_position_in  = bit_position_ff;
      second_half_in   = second_half_ff;
      in_low_phase_in  = in_low_phase_ff;
      in_end_marker_in = in_end_marker_ff;
      ticks_left_in    = ticks_left_ff;
      repeats_left_in  = repeats_left_ff;
      active_in        = active_ff;
      refused          = 1'b0;
      if (step) begin
         if (req.command == CMD_START) begin
            if (active_ff) begin
               refused = 1'b1;
            end else if (req.repeat_count != '0) begin
               frame_in = {code_ext[CODE_BITS-1:0], type_ext[TYPE_BITS-1:0],
                           req.positive, value_ext[VALUE_BITS-1:0]};
               repeats_left_in  = req.repeat_count;
               active_in        = 1'b1;
               bit_position_in  = '0;
               second_half_in   = 1'b0;
               in_end_marker_in = 1'b0;
               in_low_phase_in  = 1'b0;
               ticks_left_in    = phase_len(timing.high_ticks);
            end
         end else if (active_ff) begin
            ticks_left_in = ticks_dec;
            if (ticks_dec == '0) begin
               if (!in_low_phase_ff) begin
                  // High pulse done: open the low gap
                  in_low_phase_in = 1'b1;
                  priority if (in_end_marker_ff)
                     ticks_left_in = phase_len(timing.end_low_ticks);
                  else if (symbol)
                     ticks_left_in = phase_len(timing.short_low_ticks);
                  else
                     ticks_left_in = phase_len(timing.long_low_ticks);
               end else if (in_end_marker_ff) begin
                  // Frame gap done: repeat or drop to idle
                  repeats_left_in  = reps_dec;
                  bit_position_in  = '0;
                  second_half_in   = 1'b0;
                  in_end_marker_in = 1'b0;
                  in_low_phase_in  = 1'b0;
                  if (reps_dec == '0) begin
                     active_in     = 1'b0;
                     ticks_left_in = '0;
                  end else begin
                     ticks_left_in = phase_len(timing.high_ticks);
                  end
               end else begin
                  // Symbol gap done: advance half or bit, then a new high pulse
                  if (!second_half_ff) begin
                     second_half_in = 1'b1;
                  end else begin
                     second_half_in  = 1'b0;
                     bit_position_in = pos_inc;
                     if (pos_inc >= POS_W'(FRAME_LEN)) begin
                        in_end_marker_in = 1'b1;
                     end
                  end
                  in_low_phase_in = 1'b0;
                  ticks_left_in   = phase_len(timing.high_ticks);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_position_ff  <= '0;
         second_half_ff   <= 1'b0;
         in_low_phase_ff  <= 1'b0;
         in_end_marker_ff <= 1'b0;
         ticks_left_ff    <= '0;
         repeats_left_ff  <= '0;
         active_ff        <= 1'b0;
      end else begin
         bit_position_ff  <= bit_position_in;
         second_half_ff   <= second_half_in;
         in_low_phase_ff  <= in_low_phase_in;
         in_end_marker_ff <= in_end_marker_in;
         ticks_left_ff    <= ticks_left_in;
         repeats_left_ff  <= repeats_left_in;
         active_ff        <= active_in;
      end
   end

   always_ff @(posedge clock) begin
      frame_ff <= frame_in;
   end

   assign rsp.line_level    = active_in && !in_low_phase_in;
   assign rsp.busy_res      = active_in;
   assign rsp.start_refused = refused;

endmodule
